@@ sv/mkrc_pkg.sv @@
package mkrc_pkg;

    localparam int COLUMN_MAX     = 4;
    localparam int FIELD_WIDTH    = 64;
    localparam int MASK_WIDTH     = 4;
    localparam int COUNT_WIDTH    = 3;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 64;

    typedef logic signed [1:0] t_order;

    localparam t_order RES_EQ = 2'sb00;
    localparam t_order RES_GT = 2'sb01;
    localparam t_order RES_LT = 2'sb11;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_REF_KEY_A       = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_REF_KEY_B       = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_REF_KEY_C       = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_REF_KEY_D       = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_REF_NULL_MASK   = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DESCENDING_MASK = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_NULLS_HIGH_MASK = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_KEY_COUNT       = 3'd7;

    localparam logic [COUNT_WIDTH-1:0] KEY_COUNT_RESET = 3'd1;

    typedef struct packed {
        logic [MASK_WIDTH-1:0]  ref_null_mask;
        logic [MASK_WIDTH-1:0]  descending_mask;
        logic [MASK_WIDTH-1:0]  nulls_high_mask;
        logic [COUNT_WIDTH-1:0] key_count;
    } t_cfg;

endpackage

@@ sv/mkrc_row_if.sv @@
interface mkrc_row_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [mkrc_pkg::FIELD_WIDTH-1:0]   row_key_a;
    logic signed [mkrc_pkg::FIELD_WIDTH-1:0]   row_key_b;
    logic signed [mkrc_pkg::FIELD_WIDTH-1:0]   row_key_c;
    logic signed [mkrc_pkg::FIELD_WIDTH-1:0]   row_key_d;
    logic        [mkrc_pkg::MASK_WIDTH-1:0]    row_null_mask;
    mkrc_pkg::t_order                          prior_result;

    modport source (
        output valid, row_key_a, row_key_b, row_key_c, row_key_d,
               row_null_mask, prior_result,
        input  ready
    );
    modport sink (
        input  valid, row_key_a, row_key_b, row_key_c, row_key_d,
               row_null_mask, prior_result,
        output ready
    );
endinterface

@@ sv/mkrc_res_if.sv @@
interface mkrc_res_if;
    logic             valid;
    logic             ready;
    mkrc_pkg::t_order order_result;

    modport source (
        output valid, order_result,
        input  ready
    );
    modport sink (
        input  valid, order_result,
        output ready
    );
endinterface

@@ sv/multi_key_row_compare_top.sv @@
// A row accepted is registered in the input register, then its result in the result
// register, which holds it until taken; an output stall holds a full input register too.
// Throughput: one row per cycle while the output is not stalled, set by one pass
// of the column comparators between the input register and the result register.
// Reset (synchronous, active low) empties both stages and returns all
// configuration registers to their defaults (key_count one, others zero).
module multi_key_row_compare_top #(
    parameter int KEY_COLUMNS = 4,
    parameter int KEY_WIDTH   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mkrc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [mkrc_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    mkrc_row_if.sink                            i_row,
    mkrc_res_if.source                          o_res
);

    localparam logic [mkrc_pkg::COUNT_WIDTH-1:0] COLS = mkrc_pkg::COUNT_WIDTH'(KEY_COLUMNS);

    logic [KEY_WIDTH-1:0]             ref_key [KEY_COLUMNS];
    mkrc_pkg::t_cfg                   cfg;
    logic [mkrc_pkg::FIELD_WIDTH-1:0] row_all [mkrc_pkg::COLUMN_MAX];

    logic                             r_s1_valid;
    logic [KEY_WIDTH-1:0]             r_s1_key [KEY_COLUMNS];
    logic [KEY_COLUMNS-1:0]           r_s1_null;
    mkrc_pkg::t_order                 r_s1_prior;

    logic                             r_out_valid;
    mkrc_pkg::t_order                 r_out_result;

    mkrc_pkg::t_order                 col_result [KEY_COLUMNS];
    logic [mkrc_pkg::COUNT_WIDTH-1:0] used;
    mkrc_pkg::t_order                 n_out_result;
    logic                             advance;

    mkrc_cfg_regs #(
        .KEY_COLUMNS (KEY_COLUMNS),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ref_key   (ref_key),
        .o_cfg       (cfg)
    );

    assign row_all[0] = i_row.row_key_a;
    assign row_all[1] = i_row.row_key_b;
    assign row_all[2] = i_row.row_key_c;
    assign row_all[3] = i_row.row_key_d;

    // the output register frees whenever it is empty or being taken
    assign advance     = !r_out_valid || o_res.ready;
    assign i_row.ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_row.ready) begin
                r_s1_valid <= i_row.valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_row.valid && i_row.ready) begin
            for (int k = 0; k < KEY_COLUMNS; k++) begin
                r_s1_key[k] <= row_all[k][KEY_WIDTH-1:0];
            end
            r_s1_null  <= i_row.row_null_mask[KEY_COLUMNS-1:0];
            r_s1_prior <= i_row.prior_result;
        end
        if (advance && r_s1_valid) begin
            r_out_result <= n_out_result;
        end
    end

    for (genvar g = 0; g < KEY_COLUMNS; g++) begin : g_col
        mkrc_column_cmp #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_col (
            .i_row_key    (r_s1_key[g]),
            .i_ref_key    (ref_key[g]),
            .i_row_null   (r_s1_null[g]),
            .i_ref_null   (cfg.ref_null_mask[g]),
            .i_descending (cfg.descending_mask[g]),
            .i_nulls_high (cfg.nulls_high_mask[g]),
            .o_result     (col_result[g])
        );
    end

    assign used = (cfg.key_count > COLS) ? COLS : cfg.key_count;

    // first non-equal column among those in use decides; a set prior wins
    always_comb begin
        logic done;
        done         = 1'b0;
        n_out_result = mkrc_pkg::RES_EQ;
        for (int k = 0; k < KEY_COLUMNS; k++) begin
            if (!done && (mkrc_pkg::COUNT_WIDTH'(k) < used) &&
                (col_result[k] != mkrc_pkg::RES_EQ)) begin
                n_out_result = col_result[k];
                done         = 1'b1;
            end
        end
        if (r_s1_prior != mkrc_pkg::RES_EQ) begin
            n_out_result = r_s1_prior;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.order_result = r_out_result;

endmodule

@@ sv/mkrc_cfg_regs.sv @@
module mkrc_cfg_regs #(
    parameter int KEY_COLUMNS = 4,
    parameter int KEY_WIDTH   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mkrc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [mkrc_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    output logic [KEY_WIDTH-1:0]                o_ref_key [KEY_COLUMNS],
    output mkrc_pkg::t_cfg                      o_cfg
);

    logic [KEY_WIDTH-1:0] r_ref_key [KEY_COLUMNS];
    mkrc_pkg::t_cfg       r_cfg;

    // key registers beyond KEY_COLUMNS are not stored; writes to them drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COLUMNS; k++) begin
                r_ref_key[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            for (int k = 0; k < KEY_COLUMNS; k++) begin
                if (i_cfg_index == mkrc_pkg::CFG_IDX_WIDTH'(k)) begin
                    r_ref_key[k] <= i_cfg_data[KEY_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_null_mask   <= '0;
            r_cfg.descending_mask <= '0;
            r_cfg.nulls_high_mask <= '0;
            r_cfg.key_count       <= mkrc_pkg::KEY_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mkrc_pkg::REG_REF_NULL_MASK: begin
                    r_cfg.ref_null_mask <= i_cfg_data[mkrc_pkg::MASK_WIDTH-1:0];
                end
                mkrc_pkg::REG_DESCENDING_MASK: begin
                    r_cfg.descending_mask <= i_cfg_data[mkrc_pkg::MASK_WIDTH-1:0];
                end
                mkrc_pkg::REG_NULLS_HIGH_MASK: begin
                    r_cfg.nulls_high_mask <= i_cfg_data[mkrc_pkg::MASK_WIDTH-1:0];
                end
                mkrc_pkg::REG_KEY_COUNT: begin
                    r_cfg.key_count <= i_cfg_data[mkrc_pkg::COUNT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ref_key = r_ref_key;
    assign o_cfg     = r_cfg;

endmodule

@@ sv/mkrc_column_cmp.sv @@
module mkrc_column_cmp #(
    parameter int KEY_WIDTH = 64
) (
    input  logic             [KEY_WIDTH-1:0] i_row_key,
    input  logic             [KEY_WIDTH-1:0] i_ref_key,
    input  logic                             i_row_null,
    input  logic                             i_ref_null,
    input  logic                             i_descending,
    input  logic                             i_nulls_high,
    output mkrc_pkg::t_order                 o_result
);

    logic             lt;
    logic             gt;
    mkrc_pkg::t_order null_rank;
    mkrc_pkg::t_order null_rank_neg;

    assign lt = $signed(i_row_key) < $signed(i_ref_key);
    assign gt = $signed(i_row_key) > $signed(i_ref_key);

    assign null_rank     = i_nulls_high ? mkrc_pkg::RES_GT : mkrc_pkg::RES_LT;
    assign null_rank_neg = i_nulls_high ? mkrc_pkg::RES_LT : mkrc_pkg::RES_GT;

    // null ranks ignore the sort direction
    always_comb begin
        if (i_row_null) begin
            o_result = i_ref_null ? mkrc_pkg::RES_EQ : null_rank;
        end else if (i_ref_null) begin
            o_result = null_rank_neg;
        end else if (lt) begin
            o_result = i_descending ? mkrc_pkg::RES_GT : mkrc_pkg::RES_LT;
        end else if (gt) begin
            o_result = i_descending ? mkrc_pkg::RES_LT : mkrc_pkg::RES_GT;
        end else begin
            o_result = mkrc_pkg::RES_EQ;
        end
    end

endmodule

@@ sv/mkrc_checker.sv @@
module mkrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_result
);

    // an empty output stage never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while result stage empty");

    // a transaction on the output frees room for a new row
    a_ready_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |-> i_in_ready)
        else $error("input stalled while result is taken");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_result)))
        else $error("stalled result changed or dropped");

endmodule

bind multi_key_row_compare_top mkrc_checker u_mkrc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_row.valid),
    .i_in_ready   (i_row.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_result (o_res.order_result)
);
